[hw/rtl/qfts_pkg.sv]
// qfts_pkg: types and codes shared by the two-stack queue modules.
// Used by qfts_ctrl, qfts_dp and queue_from_two_stacks. No dependencies.
`default_nettype none

package qfts_pkg;

   localparam int DataWidth = 32;

   // Result status codes
   typedef enum logic [1:0] {
      ST_ENQ   = 2'd0,
      ST_DEQ   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Request kinds
   typedef enum logic {
      REQ_ENQ = 1'b0,
      REQ_DEQ = 1'b1
   } req_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       req_load;    // capture the incoming beat
      logic       rear_push;   // write request value on rear top
      logic       rear_pop;    // read rear top, decrement rear count
      logic       front_push;  // write moved entry on front top
      logic       front_pop;   // read front top, decrement front count
      logic       out_load;    // load the result register
      status_type out_sel;     // which result to load
   } qfts_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_deq;
      logic rear_full;
      logic rear_empty;
      logic front_empty;
      logic out_free;
   } qfts_stat_type;

endpackage

`default_nettype wire

[hw/rtl/qfts_dp.sv]
// qfts_dp: request capture, rear and front stack memories, counts and result register.
// Depends on qfts_pkg. Driven by qfts_ctrl through qfts_cmd_type.
`default_nettype none

module qfts_dp
   import qfts_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_type,
   input  wire logic [DataWidth-1:0] req_value,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [DataWidth-1:0]      rsp_data,
   output logic [1:0]                rsp_status,
   input  wire qfts_cmd_type         cmd,
   output qfts_stat_type             stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Captured request (payload, no reset)
   logic                 req_type_ff;
   logic [DataWidth-1:0] req_value_ff;

   // Stack storage and registered read data
   logic [DataWidth-1:0] rear_mem  [DEPTH];
   logic [DataWidth-1:0] front_mem [DEPTH];
   logic [DataWidth-1:0] rear_rd_ff;
   logic [DataWidth-1:0] front_rd_ff;

   // Counts
   logic [CW-1:0] rear_cnt_ff, rear_cnt_in;
   logic [CW-1:0] front_cnt_ff, front_cnt_in;
   logic [CW-1:0] rear_dec, front_dec;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0] rsp_data_ff;
   logic [1:0]           rsp_status_ff;

   assign rear_dec  = rear_cnt_ff - CW'(1);
   assign front_dec = front_cnt_ff - CW'(1);

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_type_ff  <= req_type;
         req_value_ff <= req_value;
      end
   end

   // Rear stack memory
   always_ff @(posedge clock) begin
      if (cmd.rear_push) begin
         rear_mem[rear_cnt_ff[AW-1:0]] <= req_value_ff;
      end
      if (cmd.rear_pop) begin
         rear_rd_ff <= rear_mem[rear_dec[AW-1:0]];
      end
   end

   // Front stack memory; moved entries come from the rear read register
   always_ff @(posedge clock) begin
      if (cmd.front_push) begin
         front_mem[front_cnt_ff[AW-1:0]] <= rear_rd_ff;
      end
      if (cmd.front_pop) begin
         front_rd_ff <= front_mem[front_dec[AW-1:0]];
      end
   end

   // Count updates
   always_comb begin
      rear_cnt_in = rear_cnt_ff;
      if (cmd.rear_push) begin
         rear_cnt_in = rear_cnt_ff + CW'(1);
      end else if (cmd.rear_pop) begin
         rear_cnt_in = rear_dec;
      end
      front_cnt_in = front_cnt_ff;
      if (cmd.front_push) begin
         front_cnt_in = front_cnt_ff + CW'(1);
      end else if (cmd.front_pop) begin
         front_cnt_in = front_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rear_cnt_ff  <= '0;
         front_cnt_ff <= '0;
      end else begin
         rear_cnt_ff  <= rear_cnt_in;
         front_cnt_ff <= front_cnt_in;
      end
   end

   // Result register: holds a beat until taken
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_sel;
         case (cmd.out_sel)
            ST_DEQ:   rsp_data_ff <= front_rd_ff;
            ST_EMPTY: rsp_data_ff <= '1;
            default:  rsp_data_ff <= '0;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

   // Status to the controller
   assign stat.is_deq      = (req_type_ff == REQ_DEQ);
   assign stat.rear_full   = (rear_cnt_ff == CW'(DEPTH));
   assign stat.rear_empty  = (rear_cnt_ff == '0);
   assign stat.front_empty = (front_cnt_ff == '0);
   assign stat.out_free    = ~rsp_valid_ff | rsp_ready;

endmodule

`default_nettype wire

[hw/rtl/qfts_ctrl.sv]
// qfts_ctrl: sequencer for enqueue, rear-to-front transfer and dequeue.
// Depends on qfts_pkg. Commands qfts_dp and reads its status.
`default_nettype none

module qfts_ctrl
   import qfts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire qfts_stat_type stat,
   output qfts_cmd_type       cmd
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_EXEC    = 6'b000010,
      S_MV_RD   = 6'b000100,
      S_MV_WR   = 6'b001000,
      S_POP_RD  = 6'b010000,
      S_POP_OUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.out_sel = ST_ENQ;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.is_deq) begin
               // enqueue commits together with its result
               if (stat.out_free) begin
                  cmd.out_load = 1'b1;
                  if (stat.rear_full) begin
                     cmd.out_sel = ST_FULL;
                  end else begin
                     cmd.out_sel   = ST_ENQ;
                     cmd.rear_push = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end else if (stat.rear_empty && stat.front_empty) begin
               if (stat.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = ST_EMPTY;
                  state_in     = S_IDLE;
               end
            end else if (stat.front_empty) begin
               state_in = S_MV_RD;
            end else begin
               state_in = S_POP_RD;
            end
         end
         S_MV_RD: begin
            cmd.rear_pop = 1'b1;
            state_in     = S_MV_WR;
         end
         S_MV_WR: begin
            cmd.front_push = 1'b1;
            state_in       = stat.rear_empty ? S_POP_RD : S_MV_RD;
         end
         S_POP_RD: begin
            cmd.front_pop = 1'b1;
            state_in      = S_POP_OUT;
         end
         S_POP_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = ST_DEQ;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/queue_from_two_stacks.sv]
// queue_from_two_stacks: FIFO built from a rear stack and a front stack.
// Depends on qfts_pkg, qfts_ctrl and qfts_dp.
//
//   channel | ports                                  | beat
//   --------+----------------------------------------+----------------------------
//   req     | req_valid req_ready req_type req_value | 0 enqueue value, 1 dequeue
//   rsp     | rsp_valid rsp_ready rsp_data rsp_status | one result per request
//
// Enqueue, full drop and empty dequeue go through capture, then commit.
// A dequeue with entries on the front stack goes through capture, check, read
// and result load; one that finds the front stack empty first moves each rear
// entry by a memory read and a write, as the rear memory has one registered read port.
// Reset clears both counts; the memories are not cleared.
// The result register lets the next request be captured while a result waits;
// a result only stalls the sequencer when the register is still occupied.
`default_nettype none

module queue_from_two_stacks
   import qfts_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_type,
   input  wire logic [DataWidth-1:0] req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DataWidth-1:0]      rsp_data,
   output logic [1:0]                rsp_status
);

   qfts_cmd_type  cmd;
   qfts_stat_type stat;

   // Sequencer
   qfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Stacks and result register
   qfts_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_type   (req_type),
      .req_value  (req_value),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire
